[rtl/point_rotate_project_defines.svh]
// assertion macros for the point rotate and projection block
`ifndef POINT_ROTATE_PROJECT_DEFINES_SVH
`define POINT_ROTATE_PROJECT_DEFINES_SVH

// same-cycle implication
`define PRP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("point_rotate_project check failed");

// next-cycle implication
`define PRP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("point_rotate_project check failed");

`endif

[rtl/prp_pkg.sv]
`default_nettype none

package prp_pkg;

   localparam int COL_W    = 10;
   localparam int HEIGHT_W = 13;
   localparam int ZOOM_W   = 10;
   localparam int HDIV_W   = 8;
   localparam int CSR_W    = 32;
   localparam int CIDX_W   = 3;
   localparam int HALF_W   = 16;
   localparam int CNT_W    = $clog2(ZOOM_W);

   localparam int CW   = 32;
   localparam int MW   = CW + HALF_W;
   localparam int PW   = MW + 1;
   localparam int SW   = COL_W + ZOOM_W;
   localparam int ZW   = HEIGHT_W + ZOOM_W;
   localparam int MZW  = HALF_W + ZOOM_W;
   localparam int NST  = 12;

   localparam int Q14_SHIFT = 14;
   localparam int Q14_ONE   = 16384;
   localparam int ISO_COS   = 14189;

   localparam int WINDOW_WIDTH  = 1920;
   localparam int WINDOW_HEIGHT = 1080;
   localparam int MENU_WIDTH    = 256;
   localparam int X_CENTRE      = (WINDOW_WIDTH - MENU_WIDTH) / 2 + MENU_WIDTH;

   localparam logic [CSR_W-1:0] ROT_RESET = 32'h4000_0000;

   typedef enum logic [CIDX_W-1:0] {
      REG_ROT_X,
      REG_ROT_Y,
      REG_ROT_Z,
      REG_ZOOM,
      REG_HDIV,
      REG_MODE,
      REG_MAP_SIZE,
      REG_VIEW_OFFSET
   } csr_index_type;

   typedef enum logic [1:0] {
      PROJ_NONE,
      PROJ_ISOMETRIC,
      PROJ_FRONT,
      PROJ_SIDE
   } proj_mode_type;

   // q14 product sum back to integer, rounding toward zero
   function automatic logic signed [CW-1:0] q14_trunc(input logic signed [PW-1:0] n);
      logic signed [PW-1:0] t;
      t = n + (n[PW-1] ? PW'(Q14_ONE - 1) : PW'(0));
      return t[Q14_SHIFT +: CW];
   endfunction

endpackage

`default_nettype wire

[rtl/point_rotate_project.sv]
// channel  dir  handshake             payload
// req      in   req_valid/req_ready   req_col, req_row, req_height
// rsp      out  rsp_valid/rsp_ready   rsp_screen_x, rsp_screen_y, rsp_depth
// csr      in   csr_valid/csr_ready   csr_index, csr_wdata
//
// one beat per cycle sustained while rsp_ready is high and the quotient unit is idle
// a req beat reaches the rsp beat through 12 register stages: scale, centre, three rotations
// of multiply then sum, and four projection and offset stages
// a write to zoom or height_divisor runs the quotient unit, req_ready low meanwhile
// synchronous reset clears the valid bits and loads the register defaults
// a rsp stall holds the output register while empty stages keep filling
`default_nettype none

module point_rotate_project
   import prp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [COL_W-1:0]           req_col,
   input  wire logic [COL_W-1:0]           req_row,
   input  wire logic signed [HEIGHT_W-1:0] req_height,

   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [CW-1:0]            rsp_screen_x,
   output logic signed [CW-1:0]            rsp_screen_y,
   output logic signed [CW-1:0]            rsp_depth,

   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CIDX_W-1:0]          csr_index,
   input  wire logic [CSR_W-1:0]           csr_wdata
);

   // configuration
   logic [CSR_W-1:0]  rot_x_ff, rot_y_ff, rot_z_ff, map_ff, view_ff;
   logic [ZOOM_W-1:0] zoom_ff;
   logic [HDIV_W-1:0] hdiv_ff;
   proj_mode_type     mode_ff;
   logic              csr_fire;

   // quotient unit
   logic              div_busy_ff;
   logic [CNT_W-1:0]  div_cnt_ff;
   logic [ZOOM_W-1:0] zq_ff, dvd_ff, dvd_in, new_zoom;
   logic [HDIV_W-1:0] rem_ff, rem_in, div_eff;
   logic [HDIV_W:0]   trial;
   logic              trial_ge, div_start;
   logic [SW-2:0]     div_prod;

   // derived from configuration
   logic [MZW-1:0]    mwz_ff, mhz_ff, mwz_in, mhz_in;
   logic [MZW:0]      ytop;
   logic [CW-1:0]     xoff_ff, yoff_ff, xoff_in, yoff_in;
   logic signed [HALF_W-1:0] rx_c, rx_s, ry_c, ry_s, rz_c, rz_s, pan_x, pan_y;

   // pipeline control
   logic [NST-1:0] vld_ff, vld_in, stage_en;
   logic           go, req_fire;

   // stage data
   logic [SW-1:0]           s0_xs_ff, s0_ys_ff, s0_xs_in, s0_ys_in;
   logic signed [ZW-1:0]    s0_z_ff, s0_z_in;
   logic signed [CW-1:0]    s1_x_ff, s1_y_ff, s1_z_ff, s1_x_in, s1_y_in, s1_z_in;
   logic signed [CW-1:0]    s2_x_ff;
   logic signed [MW-1:0]    s2_yc_ff, s2_zs_ff, s2_ys_ff, s2_zc_ff;
   logic signed [MW-1:0]    s2_yc_in, s2_zs_in, s2_ys_in, s2_zc_in;
   logic signed [CW-1:0]    s3_x_ff, s3_y_ff, s3_z_ff, s3_y_in, s3_z_in;
   logic signed [CW-1:0]    s4_y_ff;
   logic signed [MW-1:0]    s4_xc_ff, s4_zs_ff, s4_xs_ff, s4_zc_ff;
   logic signed [MW-1:0]    s4_xc_in, s4_zs_in, s4_xs_in, s4_zc_in;
   logic signed [CW-1:0]    s5_x_ff, s5_y_ff, s5_z_ff, s5_x_in, s5_z_in;
   logic signed [CW-1:0]    s6_z_ff;
   logic signed [MW-1:0]    s6_xc_ff, s6_ys_ff, s6_xs_ff, s6_yc_ff;
   logic signed [MW-1:0]    s6_xc_in, s6_ys_in, s6_xs_in, s6_yc_in;
   logic signed [CW-1:0]    s7_x_ff, s7_y_ff, s7_z_ff, s7_x_in, s7_y_in;
   logic signed [CW-1:0]    s8_x_ff, s8_y_ff, s8_z_ff;
   logic signed [CW:0]      s8_d_ff, s8_d_in;
   logic signed [CW+1:0]    s8_e_ff, s8_e_in, e_bias;
   logic signed [CW-1:0]    s9_x_ff, s9_y_ff, s9_z_ff, s9_iy_ff, s9_iy_in;
   logic signed [PW-1:0]    s9_ixm_ff, s9_ixm_in;
   logic signed [CW-1:0]    s10_px_ff, s10_py_ff, s10_pz_ff;
   logic signed [CW-1:0]    s10_px_in, s10_py_in, s10_pz_in;
   logic signed [CW-1:0]    s11_x_ff, s11_y_ff, s11_z_ff;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_x_ff <= ROT_RESET;
         rot_y_ff <= ROT_RESET;
         rot_z_ff <= ROT_RESET;
         zoom_ff  <= ZOOM_W'(1);
         hdiv_ff  <= HDIV_W'(1);
         mode_ff  <= PROJ_ISOMETRIC;
         map_ff   <= '0;
         view_ff  <= '0;
      end else if (csr_fire) begin
         unique case (csr_index_type'(csr_index))
            REG_ROT_X:       rot_x_ff <= csr_wdata;
            REG_ROT_Y:       rot_y_ff <= csr_wdata;
            REG_ROT_Z:       rot_z_ff <= csr_wdata;
            REG_ZOOM:        zoom_ff  <= csr_wdata[ZOOM_W-1:0];
            REG_HDIV:        hdiv_ff  <= csr_wdata[HDIV_W-1:0];
            REG_MODE:        mode_ff  <= proj_mode_type'(csr_wdata[1:0]);
            REG_MAP_SIZE:    map_ff   <= csr_wdata;
            REG_VIEW_OFFSET: view_ff  <= csr_wdata;
         endcase
      end
   end

   // zoom / height_divisor, restoring, one quotient bit a cycle
   always_comb begin
      div_start = csr_fire && (csr_index == REG_ZOOM || csr_index == REG_HDIV);
      new_zoom  = (csr_index == REG_ZOOM) ? csr_wdata[ZOOM_W-1:0] : zoom_ff;
      div_eff   = (hdiv_ff == '0) ? HDIV_W'(1) : hdiv_ff;
      trial     = {rem_ff, dvd_ff[ZOOM_W-1]};
      trial_ge  = trial >= {1'b0, div_eff};
      rem_in    = trial_ge ? HDIV_W'(trial - {1'b0, div_eff}) : trial[HDIV_W-1:0];
      dvd_in    = {dvd_ff[ZOOM_W-2:0], trial_ge};
      div_prod  = (SW-1)'(zq_ff) * (SW-1)'(div_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
         zq_ff       <= ZOOM_W'(1);
      end else if (div_start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= CNT_W'(ZOOM_W - 1);
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff - CNT_W'(1);
         if (div_cnt_ff == '0) begin
            div_busy_ff <= 1'b0;
            zq_ff       <= dvd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         dvd_ff <= new_zoom;
         rem_ff <= '0;
      end else if (div_busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   // map centring and screen offsets
   always_comb begin
      rx_c    = $signed(rot_x_ff[CSR_W-1:HALF_W]);
      rx_s    = $signed(rot_x_ff[HALF_W-1:0]);
      ry_c    = $signed(rot_y_ff[CSR_W-1:HALF_W]);
      ry_s    = $signed(rot_y_ff[HALF_W-1:0]);
      rz_c    = $signed(rot_z_ff[CSR_W-1:HALF_W]);
      rz_s    = $signed(rot_z_ff[HALF_W-1:0]);
      pan_x   = $signed(view_ff[CSR_W-1:HALF_W]);
      pan_y   = $signed(view_ff[HALF_W-1:0]);
      mwz_in  = MZW'(map_ff[CSR_W-1:HALF_W]) * MZW'(zoom_ff);
      mhz_in  = MZW'(map_ff[HALF_W-1:0]) * MZW'(zoom_ff);
      ytop    = (MZW+1)'(WINDOW_HEIGHT) + (MZW+1)'(mhz_ff);
      xoff_in = CW'(X_CENTRE) + CW'(pan_x);
      yoff_in = CW'(ytop[MZW:1]) + CW'(pan_y);
   end

   always_ff @(posedge clock) begin
      mwz_ff  <= mwz_in;
      mhz_ff  <= mhz_in;
      xoff_ff <= xoff_in;
      yoff_ff <= yoff_in;
   end

   // stage handshake, a full stage moves on when the next one is empty or moving
   always_comb begin
      go        = !vld_ff[NST-1] || rsp_ready;
      for (int k = 0; k < NST; k++) begin
         stage_en[k] = !vld_ff[k] || go;
      end
      req_ready = stage_en[0] && !div_busy_ff;
      req_fire  = req_valid && req_ready;
      vld_in[0] = stage_en[0] ? req_fire : (stage_en[1] ? 1'b0 : vld_ff[0]);
      for (int k = 1; k < NST - 1; k++) begin
         vld_in[k] = stage_en[k] ? vld_ff[k-1] : (stage_en[k+1] ? 1'b0 : vld_ff[k]);
      end
      vld_in[NST-1] = stage_en[NST-1] ? vld_ff[NST-2] : vld_ff[NST-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // datapath
   always_comb begin
      s0_xs_in = SW'(req_col) * SW'(zoom_ff);
      s0_ys_in = SW'(req_row) * SW'(zoom_ff);
      s0_z_in  = ZW'(req_height) * ZW'($signed({1'b0, zq_ff}));

      s1_x_in = CW'(s0_xs_ff) - CW'(mwz_ff[MZW-1:1]);
      s1_y_in = CW'(s0_ys_ff) - CW'(mhz_ff[MZW-1:1]);
      s1_z_in = CW'(s0_z_ff);

      s2_yc_in = MW'(s1_y_ff) * MW'(rx_c);
      s2_zs_in = MW'(s1_z_ff) * MW'(rx_s);
      s2_ys_in = MW'(s1_y_ff) * MW'(rx_s);
      s2_zc_in = MW'(s1_z_ff) * MW'(rx_c);

      s3_y_in = q14_trunc(PW'(s2_yc_ff) + PW'(s2_zs_ff));
      s3_z_in = q14_trunc(PW'(s2_zc_ff) - PW'(s2_ys_ff));

      s4_xc_in = MW'(s3_x_ff) * MW'(ry_c);
      s4_zs_in = MW'(s3_z_ff) * MW'(ry_s);
      s4_xs_in = MW'(s3_x_ff) * MW'(ry_s);
      s4_zc_in = MW'(s3_z_ff) * MW'(ry_c);

      s5_x_in = q14_trunc(PW'(s4_xc_ff) - PW'(s4_zs_ff));
      s5_z_in = q14_trunc(PW'(s4_xs_ff) + PW'(s4_zc_ff));

      s6_xc_in = MW'(s5_x_ff) * MW'(rz_c);
      s6_ys_in = MW'(s5_y_ff) * MW'(rz_s);
      s6_xs_in = MW'(s5_x_ff) * MW'(rz_s);
      s6_yc_in = MW'(s5_y_ff) * MW'(rz_c);

      s7_x_in = q14_trunc(PW'(s6_xc_ff) - PW'(s6_ys_ff));
      s7_y_in = q14_trunc(PW'(s6_xs_ff) + PW'(s6_yc_ff));

      s8_d_in = (CW+1)'(s7_x_ff) - (CW+1)'(s7_y_ff);
      s8_e_in = (CW+2)'(s7_x_ff) + (CW+2)'(s7_y_ff) - ((CW+2)'(s7_z_ff) <<< 1);

      s9_ixm_in = PW'(s8_d_ff) * PW'(ISO_COS);
      e_bias    = s8_e_ff + $signed({{(CW+1){1'b0}}, s8_e_ff[CW+1]});
      s9_iy_in  = e_bias[CW:1];

      unique case (mode_ff)
         PROJ_NONE: begin
            s10_px_in = s9_x_ff;
            s10_py_in = s9_y_ff;
            s10_pz_in = s9_z_ff;
         end
         PROJ_ISOMETRIC: begin
            s10_px_in = q14_trunc(s9_ixm_ff);
            s10_py_in = s9_iy_ff;
            s10_pz_in = s9_z_ff;
         end
         PROJ_FRONT: begin
            s10_px_in = s9_x_ff;
            s10_py_in = -s9_z_ff;
            s10_pz_in = s9_y_ff;
         end
         PROJ_SIDE: begin
            s10_px_in = -s9_y_ff;
            s10_py_in = -s9_z_ff;
            s10_pz_in = s9_x_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s0_xs_ff <= s0_xs_in;
         s0_ys_ff <= s0_ys_in;
         s0_z_ff  <= s0_z_in;
      end
      if (stage_en[1]) begin
         s1_x_ff <= s1_x_in;
         s1_y_ff <= s1_y_in;
         s1_z_ff <= s1_z_in;
      end
      if (stage_en[2]) begin
         s2_x_ff  <= s1_x_ff;
         s2_yc_ff <= s2_yc_in;
         s2_zs_ff <= s2_zs_in;
         s2_ys_ff <= s2_ys_in;
         s2_zc_ff <= s2_zc_in;
      end
      if (stage_en[3]) begin
         s3_x_ff <= s2_x_ff;
         s3_y_ff <= s3_y_in;
         s3_z_ff <= s3_z_in;
      end
      if (stage_en[4]) begin
         s4_y_ff  <= s3_y_ff;
         s4_xc_ff <= s4_xc_in;
         s4_zs_ff <= s4_zs_in;
         s4_xs_ff <= s4_xs_in;
         s4_zc_ff <= s4_zc_in;
      end
      if (stage_en[5]) begin
         s5_x_ff <= s5_x_in;
         s5_y_ff <= s4_y_ff;
         s5_z_ff <= s5_z_in;
      end
      if (stage_en[6]) begin
         s6_z_ff  <= s5_z_ff;
         s6_xc_ff <= s6_xc_in;
         s6_ys_ff <= s6_ys_in;
         s6_xs_ff <= s6_xs_in;
         s6_yc_ff <= s6_yc_in;
      end
      if (stage_en[7]) begin
         s7_x_ff <= s7_x_in;
         s7_y_ff <= s7_y_in;
         s7_z_ff <= s6_z_ff;
      end
      if (stage_en[8]) begin
         s8_x_ff <= s7_x_ff;
         s8_y_ff <= s7_y_ff;
         s8_z_ff <= s7_z_ff;
         s8_d_ff <= s8_d_in;
         s8_e_ff <= s8_e_in;
      end
      if (stage_en[9]) begin
         s9_x_ff   <= s8_x_ff;
         s9_y_ff   <= s8_y_ff;
         s9_z_ff   <= s8_z_ff;
         s9_ixm_ff <= s9_ixm_in;
         s9_iy_ff  <= s9_iy_in;
      end
      if (stage_en[10]) begin
         s10_px_ff <= s10_px_in;
         s10_py_ff <= s10_py_in;
         s10_pz_ff <= s10_pz_in;
      end
      if (stage_en[11]) begin
         s11_x_ff <= s10_px_ff + xoff_ff;
         s11_y_ff <= s10_py_ff + yoff_ff;
         s11_z_ff <= s10_pz_ff;
      end
   end

   assign rsp_valid    = vld_ff[NST-1];
   assign rsp_screen_x = s11_x_ff;
   assign rsp_screen_y = s11_y_ff;
   assign rsp_depth    = s11_z_ff;

`include "point_rotate_project_defines.svh"

   `PRP_ASSERT_NEXT(a_div_start, div_start, div_busy_ff)
   `PRP_ASSERT_NOW(a_quot_low, req_fire, div_prod <= (SW-1)'(zoom_ff))
   `PRP_ASSERT_NOW(a_quot_rem, req_fire, (SW-1)'(zoom_ff) - div_prod < (SW-1)'(div_eff))
   `PRP_ASSERT_NEXT(a_enter, req_fire, vld_ff[0])

endmodule

`default_nettype wire
